// ----- design/sdfb_pkg.sv -----
// Shared types, command codes and lookup tables for the segment display frame builder.
`timescale 1ns / 1ps

package sdfb_pkg;

  // Command codes carried by a request and by a queued operation.
  localparam logic [1:0] CMD_FLAG    = 2'd0;
  localparam logic [1:0] CMD_GEAR    = 2'd1;
  localparam logic [1:0] CMD_TEMP    = 2'd2;
  localparam logic [1:0] CMD_REFRESH = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_DATA_MODE  = 2'd0;
  localparam logic [1:0] REG_ADDR_BASE  = 2'd1;
  localparam logic [1:0] REG_DISPLAY_ON = 2'd2;
  localparam logic [1:0] REG_VARIANT    = 2'd3;

  localparam logic [7:0] DATA_MODE_RESET  = 8'h40;
  localparam logic [7:0] ADDR_BASE_RESET  = 8'hC0;
  localparam logic [7:0] DISPLAY_ON_RESET = 8'h8F;

  localparam logic [7:0] DASH_CODE = 8'h04;

  localparam int          NUM_FLAGS   = 6;
  localparam int          FRAME_LEN   = 11;
  localparam int          CONV_STEPS  = 15;
  localparam int          EMIT_CNT_W  = $clog2(FRAME_LEN);
  localparam int          CONV_CNT_W  = $clog2(CONV_STEPS);

  // One decoded operation handed from the front to the back.
  typedef struct packed {
    logic [1:0] code;
    logic       row;
    logic [2:0] byte_idx;
    logic       flag_on;
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
  } op_t;

  function automatic logic [7:0] digit_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'hFA;
      4'd1:    code = 8'h60;
      4'd2:    code = 8'hBC;
      4'd3:    code = 8'hF4;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'hD6;
      4'd6:    code = 8'hDE;
      4'd7:    code = 8'h70;
      4'd8:    code = 8'hFE;
      4'd9:    code = 8'hF6;
      default: code = 8'hFA;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] bar_code(input logic [3:0] level);
    logic [7:0] code;
    case (level)
      4'd0:    code = 8'h00;
      4'd1:    code = 8'h08;
      4'd2:    code = 8'h0C;
      4'd3:    code = 8'h0E;
      4'd4:    code = 8'h0F;
      4'd5:    code = 8'h1F;
      4'd6:    code = 8'h3F;
      4'd7:    code = 8'h7F;
      default: code = 8'hFF;
    endcase
    return code;
  endfunction

  function automatic logic [2:0] flag_byte(input logic [2:0] sel);
    logic [2:0] idx;
    case (sel)
      3'd0:    idx = 3'd1;
      3'd1:    idx = 3'd0;
      3'd2:    idx = 3'd4;
      3'd3:    idx = 3'd5;
      3'd4:    idx = 3'd6;
      3'd5:    idx = 3'd2;
      default: idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

// ----- design/sdfb_front.sv -----
// Front end: takes requests, decodes them and converts temperatures to digit codes.
`timescale 1ns / 1ps

module sdfb_front
  import sdfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [2:0]  flag_select,
  input  logic        flag_on,
  input  logic [7:0]  gear,
  input  logic [15:0] temperature,
  input  logic        temp_row,
  input  logic        q_full,
  output logic        push,
  output op_t         push_op
);

  logic                  conv_active;
  logic                  pend_valid;
  op_t                   pend;
  logic [14:0]           bin;
  logic [11:0]           bcd;
  logic [CONV_CNT_W-1:0] conv_cnt;
  logic [11:0]           bcd_next;
  logic                  accept;
  logic                  conv_done;

  assign busy    = rst | pend_valid | conv_active;
  assign accept  = start & ~busy;
  assign push    = pend_valid & ~q_full;
  assign push_op = pend;
  assign conv_done = conv_active && (conv_cnt == CONV_CNT_W'(CONV_STEPS - 1));

  // One double-dabble step. Only the low three digits are kept, which
  // directly gives the value modulo 1000.
  always_comb begin
    logic [11:0] adj;
    adj = bcd;
    for (int d = 0; d < 3; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    bcd_next = {adj[10:0], bin[14]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_active <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      if (push) begin
        pend_valid <= 1'b0;
      end
      if (conv_done) begin
        conv_active <= 1'b0;
        pend_valid  <= 1'b1;
      end
      if (accept) begin
        case (command)
          CMD_FLAG: begin
            if (flag_select < 3'(NUM_FLAGS)) begin
              pend_valid <= 1'b1;
            end
          end
          CMD_TEMP: begin
            if (temperature[15]) begin
              pend_valid <= 1'b1;
            end else begin
              conv_active <= 1'b1;
            end
          end
          default: pend_valid <= 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend.code     <= command;
      pend.row      <= temp_row;
      pend.byte_idx <= flag_byte(flag_select);
      pend.flag_on  <= flag_on;
      if (command == CMD_TEMP) begin
        pend.d0 <= DASH_CODE;
      end else begin
        pend.d0 <= (gear > 8'd8) ? bar_code(4'd8) : bar_code(gear[3:0]);
      end
      pend.d1       <= DASH_CODE;
      pend.d2       <= DASH_CODE;
      bin      <= temperature[14:0];
      bcd      <= '0;
      conv_cnt <= '0;
    end else if (conv_active) begin
      bin      <= {bin[13:0], 1'b0};
      bcd      <= bcd_next;
      conv_cnt <= conv_cnt + 1'b1;
      if (conv_done) begin
        pend.d0 <= digit_code(bcd_next[11:8]);
        pend.d1 <= digit_code(bcd_next[7:4]);
        pend.d2 <= digit_code(bcd_next[3:0]);
      end
    end
  end

endmodule

// ----- design/sdfb_queue.sv -----
// Small operation queue between the front end and the back end.
`timescale 1ns / 1ps

module sdfb_queue
  import sdfb_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic valid,
  output op_t  head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/sdfb_back.sv -----
// Back end: holds the segment store, applies updates and streams refresh frames.
`timescale 1ns / 1ps

module sdfb_back
  import sdfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  op_t        q_op,
  output logic       pop,
  input  logic [7:0] data_mode_command,
  input  logic [7:0] address_command_base,
  input  logic [7:0] display_on_command,
  input  logic       variant_patch,
  output logic       result_valid,
  output logic [7:0] out_byte,
  output logic       frame_end,
  output logic       last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                  state;
  logic [EMIT_CNT_W-1:0] cnt;
  logic [7:0][7:0]       store;
  logic [EMIT_CNT_W-1:0] drv_sel;
  logic [7:0]            drv_byte;

  // Driver byte 2i+h collects bits i and 4+i of store row h, bytes 0..3.
  function automatic logic [7:0] gather(input logic [7:0][7:0] s, input logic [2:0] j);
    logic [7:0] v;
    logic [2:0] idx;
    for (int k = 0; k < 4; k++) begin
      idx          = {j[0], 2'(k)};
      v[2*k]       = s[idx][{1'b0, j[2:1]}];
      v[2*k + 1]   = s[idx][{1'b1, j[2:1]}];
    end
    return v;
  endfunction

  assign pop     = (state == ST_IDLE) && q_valid;
  assign drv_sel = cnt - EMIT_CNT_W'(2);

  always_comb begin
    drv_byte = gather(store, drv_sel[2:0]);
    if (variant_patch && drv_sel[1:0] == 2'd3) begin
      drv_byte[0] = drv_sel[2] ? store[4][1] : store[4][3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      store        <= '0;
      result_valid <= 1'b0;
      last         <= 1'b0;
    end else begin
      result_valid <= (state == ST_EMIT);
      last         <= (state == ST_EMIT) && (cnt == EMIT_CNT_W'(FRAME_LEN - 1));
      case (state)
        ST_IDLE: begin
          if (pop) begin
            case (q_op.code)
              CMD_FLAG:    store[q_op.byte_idx][0] <= q_op.flag_on;
              CMD_GEAR:    store[3] <= q_op.d0;
              CMD_TEMP: begin
                store[{q_op.row, 2'd0}] <= q_op.d0;
                store[{q_op.row, 2'd1}] <= q_op.d1;
                store[{q_op.row, 2'd2}] <= q_op.d2;
              end
              default: begin
                state <= ST_EMIT;
                cnt   <= '0;
              end
            endcase
          end
        end
        ST_EMIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == EMIT_CNT_W'(FRAME_LEN - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cnt == '0) begin
      out_byte  <= data_mode_command;
      frame_end <= 1'b1;
    end else if (cnt == EMIT_CNT_W'(1)) begin
      out_byte  <= address_command_base;
      frame_end <= 1'b0;
    end else if (cnt == EMIT_CNT_W'(FRAME_LEN - 1)) begin
      out_byte  <= display_on_command;
      frame_end <= 1'b1;
    end else begin
      out_byte  <= drv_byte;
      frame_end <= (cnt == EMIT_CNT_W'(FRAME_LEN - 2));
    end
  end

endmodule

// ----- design/segment_display_frame_builder_core.sv -----
// Top level of the segment display frame builder: configuration, front end, queue, back end.
//
//  Channel   Direction  Handshake                      Payload
//  request   in         start & !busy                  command, flag_select, flag_on,
//                                                      gear, temperature, temp_row
//  result    out        result_valid (one cycle each)  out_byte, frame_end, last
//  config    in         cfg_valid & cfg_ready          cfg_index, cfg_data
//
// An update request passes from the front end's pending register through the
// queue to the store; the back end pops it only while no refresh is streaming.
// The front end takes no new request until its decoded one has left for the
// queue. A non-negative temperature first runs 15 steps of the shift-and-adjust
// digit converter. A refresh yields its 11 bytes back to back once the back end
// has popped it, and the back end pops nothing else until the frame is out.
// Reset clears the store to zero and loads the default command bytes. Busy is
// high during reset, while a request is decoded or converted, and while a
// decoded request waits for room in the queue. The result side cannot stall.
`timescale 1ns / 1ps

module segment_display_frame_builder_core
  import sdfb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [2:0]  flag_select,
  input  logic        flag_on,
  input  logic [7:0]  gear,
  input  logic [15:0] temperature,
  input  logic        temp_row,
  output logic        result_valid,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] data_mode_command;
  logic [7:0] address_command_base;
  logic [7:0] display_on_command;
  logic       variant_patch;

  logic q_full;
  logic q_push;
  op_t  q_push_op;
  logic q_pop;
  logic q_valid;
  op_t  q_head;

  // Configuration registers are always writable; the user must write them only
  // while no refresh is in progress, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_mode_command    <= DATA_MODE_RESET;
      address_command_base <= ADDR_BASE_RESET;
      display_on_command   <= DISPLAY_ON_RESET;
      variant_patch        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DATA_MODE:  data_mode_command    <= cfg_data;
        REG_ADDR_BASE:  address_command_base <= cfg_data;
        REG_DISPLAY_ON: display_on_command   <= cfg_data;
        REG_VARIANT:    variant_patch        <= cfg_data[0];
        default:        variant_patch        <= variant_patch;
      endcase
    end
  end

  // The front end decodes each request; non-negative temperatures pass through
  // the digit converter before the decoded operation is queued.
  sdfb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .flag_select (flag_select),
    .flag_on     (flag_on),
    .gear        (gear),
    .temperature (temperature),
    .temp_row    (temp_row),
    .q_full      (q_full),
    .push        (q_push),
    .push_op     (q_push_op)
  );

  // The queue lets the front end keep decoding while a refresh is streaming.
  sdfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_push_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  // The back end owns the segment store and the output byte stream.
  sdfb_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .q_valid              (q_valid),
    .q_op                 (q_head),
    .pop                  (q_pop),
    .data_mode_command    (data_mode_command),
    .address_command_base (address_command_base),
    .display_on_command   (display_on_command),
    .variant_patch        (variant_patch),
    .result_valid         (result_valid),
    .out_byte             (out_byte),
    .frame_end            (frame_end),
    .last                 (last)
  );

endmodule

// ----- design/sdfb_checker.sv -----
// Port-level checker for the frame builder, bound to the top level.
`timescale 1ns / 1ps

module sdfb_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic result_valid,
  input logic frame_end,
  input logic last
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result strobe right after reset");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> frame_end)
    else $error("final byte does not end a frame");

  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid)
    else $error("refresh byte run broken before its final byte");

  a_gap_after_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("result strobe directly after a final byte");

  a_busy_in_reset: assert property (@(posedge clk) rst |-> busy)
    else $error("busy low during reset");

endmodule

bind segment_display_frame_builder_core sdfb_checker u_sdfb_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .frame_end    (frame_end),
  .last         (last)
);

// ----- bench/testbench.sv -----
// Self-checking testbench for the segment display frame builder core.
`timescale 1ns / 1ps

module testbench;
  import sdfb_pkg::*;

  // Clock period, settle time after the last expected byte, and the hard run limit.
  localparam int CLK_PERIOD    = 20;
  localparam int SETTLE_CYCLES = 40;
  localparam int RUN_LIMIT_NS  = 10_000_000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 70;
  localparam int REPORT_LIMIT  = 10;

  // Flag select codes of the six flags.
  localparam logic [2:0] FLAG_FIX     = 3'd0;
  localparam logic [2:0] FLAG_ERROR   = 3'd1;
  localparam logic [2:0] FLAG_NO_TOOL = 3'd2;
  localparam logic [2:0] FLAG_UNIT_C  = 3'd3;
  localparam logic [2:0] FLAG_UNIT_F  = 3'd4;
  localparam logic [2:0] FLAG_UNIT_H  = 3'd5;

  // One byte of a refresh stream as it should appear on the result ports.
  typedef struct {
    logic [7:0] value;
    logic       frame_end;
    logic       last;
  } frame_byte_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [2:0]  flag_select;
  logic        flag_on;
  logic [7:0]  gear;
  logic [15:0] temperature;
  logic        temp_row;
  logic        result_valid;
  logic [7:0]  out_byte;
  logic        frame_end;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  segment_display_frame_builder_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .flag_select  (flag_select),
    .flag_on      (flag_on),
    .gear         (gear),
    .temperature  (temperature),
    .temp_row     (temp_row),
    .result_valid (result_valid),
    .out_byte     (out_byte),
    .frame_end    (frame_end),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Our own image of the panel: the eight segment bytes and the command bytes
  // that frame a refresh. It advances at the edge where the core takes a request,
  // so it always reflects every request accepted so far.
  logic [7:0] seg_image [8];
  logic [7:0] data_mode_byte;
  logic [7:0] addr_base_byte;
  logic [7:0] display_on_byte;
  logic       variant_on;

  // Bytes the core still owes us, oldest first.
  frame_byte_t pending_bytes [$];

  int error_count;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop: a hang anywhere in the run ends up here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("testbench failed");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Panel predictor
  // ------------------------------------------------------------------------

  // Seven-segment code of one decimal digit.
  function automatic logic [7:0] digit_segments(input int digit);
    logic [7:0] seg;
    case (digit)
      0:       seg = 8'hFA;
      1:       seg = 8'h60;
      2:       seg = 8'hBC;
      3:       seg = 8'hF4;
      4:       seg = 8'h66;
      5:       seg = 8'hD6;
      6:       seg = 8'hDE;
      7:       seg = 8'h70;
      8:       seg = 8'hFE;
      default: seg = 8'hF6;
    endcase
    return seg;
  endfunction

  // Bar graph for a power gear already limited to 0..8.
  function automatic logic [7:0] gear_bar(input int level);
    logic [7:0] bar;
    case (level)
      0:       bar = 8'h00;
      1:       bar = 8'h08;
      2:       bar = 8'h0C;
      3:       bar = 8'h0E;
      4:       bar = 8'h0F;
      5:       bar = 8'h1F;
      6:       bar = 8'h3F;
      7:       bar = 8'h7F;
      default: bar = 8'hFF;
    endcase
    return bar;
  endfunction

  // One driver byte built from four store bytes starting at row_base: the low
  // bit of each pair comes from segment bit `column`, the high bit from column+4.
  function automatic logic [7:0] driver_column(input int row_base, input int column);
    logic [7:0] col_bits;
    int         k;
    col_bits = 8'h00;
    for (k = 0; k < 4; k++) begin
      col_bits[2 * k]     = seg_image[row_base + k][column];
      col_bits[2 * k + 1] = seg_image[row_base + k][column + 4];
    end
    return col_bits;
  endfunction

  function automatic frame_byte_t frame_byte(input logic [7:0] value, input logic fe,
                                             input logic lst);
    frame_byte_t fb;
    fb.value     = value;
    fb.frame_end = fe;
    fb.last      = lst;
    return fb;
  endfunction

  // Applies one accepted request to the panel image and, for a refresh, queues
  // the eleven bytes of the outgoing stream.
  task automatic apply_request(input logic [1:0] cmd, input logic [2:0] fsel,
                               input logic fon, input logic [7:0] gear_lvl,
                               input logic [15:0] temp, input logic row);
    logic [7:0] drv [8];
    int         base;
    int         level;
    int         shown;
    int         target;
    int         i;
    base = row ? 4 : 0;
    case (cmd)
      CMD_FLAG: begin
        case (fsel)
          FLAG_FIX:     target = 1;
          FLAG_ERROR:   target = 0;
          FLAG_NO_TOOL: target = 4;
          FLAG_UNIT_C:  target = 5;
          FLAG_UNIT_F:  target = 6;
          FLAG_UNIT_H:  target = 2;
          default:      target = -1;  // unused selects leave the store alone
        endcase
        if (target >= 0) begin
          seg_image[target][0] = fon;
        end
      end
      CMD_GEAR: begin
        level = (gear_lvl > 8) ? 8 : int'(gear_lvl);
        seg_image[3] = gear_bar(level);
      end
      CMD_TEMP: begin
        // Negative readings show three dashes; otherwise only the value modulo
        // 1000 is displayed. Either way the flag bits in these bytes are lost.
        if (temp[15]) begin
          for (i = 0; i < 3; i++) begin
            seg_image[base + i] = DASH_CODE;
          end
        end else begin
          shown = int'(temp[14:0]) % 1000;
          seg_image[base]     = digit_segments(shown / 100);
          seg_image[base + 1] = digit_segments((shown / 10) % 10);
          seg_image[base + 2] = digit_segments(shown % 10);
        end
      end
      default: begin
        for (i = 0; i < 4; i++) begin
          drv[2 * i]     = driver_column(0, i);
          drv[2 * i + 1] = driver_column(4, i);
        end
        if (variant_on) begin
          drv[3][0] = seg_image[4][3];
          drv[7][0] = seg_image[4][1];
        end
        pending_bytes.push_back(frame_byte(data_mode_byte, 1'b1, 1'b0));
        pending_bytes.push_back(frame_byte(addr_base_byte, 1'b0, 1'b0));
        for (i = 0; i < 8; i++) begin
          pending_bytes.push_back(frame_byte(drv[i], i == 7, 1'b0));
        end
        pending_bytes.push_back(frame_byte(display_on_byte, 1'b1, 1'b1));
      end
    endcase
  endtask

  // ------------------------------------------------------------------------
  // Result checker
  // ------------------------------------------------------------------------

  // Every strobed byte is matched against the oldest byte still owed. A strobe
  // with nothing owed is a failure in its own right.
  always @(posedge clk) begin : check_stream
    frame_byte_t want;
    if (!rst && result_valid) begin
      if (pending_bytes.size() == 0) begin
        if (error_count < REPORT_LIMIT) begin
          $display("%0t: unexpected byte %02h frame_end %b last %b", $time,
                   out_byte, frame_end, last);
        end
        error_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.value || frame_end !== want.frame_end ||
            last !== want.last) begin
          if (error_count < REPORT_LIMIT) begin
            $display("%0t: stream mismatch: expected %02h/%b/%b, got %02h/%b/%b", $time,
                     want.value, want.frame_end, want.last, out_byte, frame_end, last);
          end
          error_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Request, configuration and drain helpers
  // ------------------------------------------------------------------------

  // Sends one request. Requests go out in bursts of random length; between
  // bursts start drops for a random number of cycles, and some bursts follow
  // straight on so that start stays high across back-to-back requests.
  task automatic send_request(input logic [1:0] cmd, input logic [2:0] fsel,
                              input logic fon, input logic [7:0] gear_lvl,
                              input logic [15:0] temp, input logic row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start       <= 1'b1;
    command     <= cmd;
    flag_select <= fsel;
    flag_on     <= fon;
    gear        <= gear_lvl;
    temperature <= temp;
    temp_row    <= row;
    do @(posedge clk); while (busy);
    apply_request(cmd, fsel, fon, gear_lvl, temp, row);
  endtask

  // Drops start, waits for every owed byte, then lets the update pipeline and
  // the digit converter run out, since updates leave no bytes to wait for.
  task automatic drain_requests();
    @(negedge clk);
    start <= 1'b0;
    burst_left = 0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one configuration register; only called with the core drained.
  task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DATA_MODE:  data_mode_byte  = data;
      REG_ADDR_BASE:  addr_base_byte  = data;
      REG_DISPLAY_ON: display_on_byte = data;
      default:        variant_on      = data[0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_registers(input logic [7:0] dm, input logic [7:0] ab,
                                     input logic [7:0] don, input logic [7:0] var_data);
    drain_requests();
    write_register(REG_DATA_MODE, dm);
    write_register(REG_ADDR_BASE, ab);
    write_register(REG_DISPLAY_ON, don);
    write_register(REG_VARIANT, var_data);
  endtask

  task automatic refresh_panel();
    send_request(CMD_REFRESH, 3'($urandom), 1'($urandom), 8'($urandom),
                 16'($urandom), 1'($urandom));
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // A refresh straight after reset: blank store and the default command bytes.
  task automatic test_reset_state();
    refresh_panel();
  endtask

  // Every flag select set, including the two unused codes, then one cleared.
  task automatic test_flag_bits();
    int sel;
    for (sel = 0; sel < 8; sel++) begin
      send_request(CMD_FLAG, 3'(sel), 1'b1, 8'h00, 16'h0000, 1'b0);
    end
    send_request(CMD_FLAG, FLAG_UNIT_F, 1'b0, 8'h00, 16'h0000, 1'b0);
    refresh_panel();
  endtask

  // Gear saturation at the top of the range, then the empty bar.
  task automatic test_gear_bars();
    send_request(CMD_GEAR, 3'd0, 1'b0, 8'hFF, 16'h0000, 1'b0);
    refresh_panel();
    send_request(CMD_GEAR, 3'd0, 1'b0, 8'd9, 16'h0000, 1'b0);
    send_request(CMD_GEAR, 3'd0, 1'b0, 8'd0, 16'h0000, 1'b0);
  endtask

  // Largest positive value wraps modulo 1000, most negative value shows dashes,
  // and a digit write clears whatever flag bits were set in its row.
  task automatic test_temperature();
    send_request(CMD_TEMP, 3'd0, 1'b0, 8'h00, 16'h7FFF, 1'b0);
    send_request(CMD_TEMP, 3'd0, 1'b0, 8'h00, 16'h8000, 1'b1);
    refresh_panel();
    send_request(CMD_TEMP, 3'd0, 1'b0, 8'h00, 16'd999, 1'b0);
    send_request(CMD_TEMP, 3'd0, 1'b0, 8'h00, 16'd0, 1'b1);
    send_request(CMD_TEMP, 3'd0, 1'b0, 8'h00, 16'hFFFF, 1'b0);
    refresh_panel();
  endtask

  // Command bytes at both extremes, with the panel variant patch on for the first refresh.
  task automatic test_register_extremes();
    write_all_registers(8'h00, 8'hFF, 8'h00, 8'h01);
    send_request(CMD_TEMP, 3'd0, 1'b0, 8'h00, 16'd888, 1'b1);
    refresh_panel();
    write_all_registers(8'hFF, 8'h00, 8'hFF, 8'hFE);
    refresh_panel();
  endtask

  // Random traffic in phases, each under its own register setting. All fields
  // are random on every request, including the ones the command ignores.
  task automatic test_random_traffic();
    int          phase;
    int          n;
    logic [15:0] temp;
    logic [7:0]  gear_lvl;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       write_all_registers(8'h00, 8'h00, 8'h00, 8'h00);
        1:       write_all_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        4:       write_all_registers(DATA_MODE_RESET, ADDR_BASE_RESET, DISPLAY_ON_RESET,
                                     8'($urandom));
        default: write_all_registers(8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom));
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        gear_lvl = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 9)) : 8'($urandom);
        case ($urandom_range(0, 3))
          0:       temp = 16'($urandom_range(0, 999));
          1:       temp = 16'($urandom_range(0, 32767));
          2:       temp = 16'h8000 | 16'($urandom_range(0, 32767));
          default: temp = 16'($urandom);
        endcase
        send_request(2'($urandom_range(0, 3)), 3'($urandom), 1'($urandom), gear_lvl,
                     temp, 1'($urandom));
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    int i;
    rst         = 1'b1;
    start       = 1'b0;
    command     = CMD_FLAG;
    flag_select = 3'd0;
    flag_on     = 1'b0;
    gear        = 8'h00;
    temperature = 16'h0000;
    temp_row    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_DATA_MODE;
    cfg_data    = 8'h00;
    error_count = 0;
    burst_left  = 0;
    for (i = 0; i < 8; i++) begin
      seg_image[i] = 8'h00;
    end
    data_mode_byte  = DATA_MODE_RESET;
    addr_base_byte  = ADDR_BASE_RESET;
    display_on_byte = DISPLAY_ON_RESET;
    variant_on      = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_flag_bits();
    test_gear_bars();
    test_temperature();
    test_register_extremes();
    test_random_traffic();
    drain_requests();

    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/sdfb_pkg.sv
design/sdfb_front.sv
design/sdfb_queue.sv
design/sdfb_back.sv
design/segment_display_frame_builder_core.sv
design/sdfb_checker.sv
bench/testbench.sv
